// File: rtl/dotq_pkg.sv
// shared types, constants and helpers for the deadline ordered timer queue
// used by dotq_ctrl, dotq_datapath and deadline_ordered_timer_queue
package dotq_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int MAX_FIRES = 16;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
    localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

    localparam logic [31:0] RESET_INTERVAL_MIN = 32'd50;
    localparam logic [31:0] RESET_INTERVAL_MAX = 32'd50000000;

    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_CANCEL = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_RSVD   = 2'd3;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic CFG_INTERVAL_MIN = 1'b0;
    localparam logic CFG_INTERVAL_MAX = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ARM,
        ST_CANCEL,
        ST_INS_WALK,
        ST_FIRE_HEAD,
        ST_FIRE_TEST,
        ST_STAT_HEAD,
        ST_STAT_DIFF,
        ST_STAT_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic arm;
        logic cancel;
        logic tick;
        logic ins_rd;
        logic ins_step;
        logic ins_put;
        logic head_read;
        logic fire;
        logic diff;
        logic status;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       slot_ok;
        logic       ins_more;
        logic       due;
        logic       periodic;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

// File: rtl/dotq_ctrl.sv
// controller state machine for the timer queue
// depends on dotq_pkg; drives dotq_datapath through dp_cmd_t
module dotq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dotq_pkg::dp_stat_t st,
    output dotq_pkg::dp_cmd_t  cmd
);

    dotq_pkg::state_t state_reg;
    dotq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dotq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            dotq_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dotq_pkg::ST_DISPATCH;
                end
            end
            dotq_pkg::ST_DISPATCH:
            begin
                if (st.op == dotq_pkg::OP_ARM && st.slot_ok)
                begin
                    state_next = dotq_pkg::ST_ARM;
                end
                else if (st.op == dotq_pkg::OP_CANCEL && st.slot_ok)
                begin
                    state_next = dotq_pkg::ST_CANCEL;
                end
                else if (st.op == dotq_pkg::OP_TICK)
                begin
                    cmd.tick   = 1'b1;
                    state_next = dotq_pkg::ST_FIRE_HEAD;
                end
                else
                begin
                    state_next = dotq_pkg::ST_STAT_HEAD;
                end
            end
            dotq_pkg::ST_ARM:
            begin
                cmd.arm    = 1'b1;
                state_next = dotq_pkg::ST_INS_WALK;
            end
            dotq_pkg::ST_CANCEL:
            begin
                cmd.cancel = 1'b1;
                state_next = dotq_pkg::ST_STAT_HEAD;
            end
            dotq_pkg::ST_INS_WALK:
            begin
                cmd.ins_rd = 1'b1;
                if (st.ins_more)
                begin
                    cmd.ins_step = 1'b1;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = (st.op == dotq_pkg::OP_TICK) ? dotq_pkg::ST_FIRE_HEAD
                                                               : dotq_pkg::ST_STAT_HEAD;
                end
            end
            dotq_pkg::ST_FIRE_HEAD:
            begin
                cmd.head_read = 1'b1;
                state_next    = dotq_pkg::ST_FIRE_TEST;
            end
            dotq_pkg::ST_FIRE_TEST:
            begin
                if (!st.due)
                begin
                    state_next = dotq_pkg::ST_STAT_HEAD;
                end
                else if (st.out_free)
                begin
                    cmd.fire   = 1'b1;
                    state_next = st.periodic ? dotq_pkg::ST_INS_WALK : dotq_pkg::ST_FIRE_HEAD;
                end
            end
            dotq_pkg::ST_STAT_HEAD:
            begin
                cmd.head_read = 1'b1;
                state_next    = dotq_pkg::ST_STAT_DIFF;
            end
            dotq_pkg::ST_STAT_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = dotq_pkg::ST_STAT_EMIT;
            end
            dotq_pkg::ST_STAT_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.status = 1'b1;
                    state_next = dotq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dotq_pkg::ST_IDLE;
            end
        endcase
    end

    a_fire_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |=> (state_reg == dotq_pkg::ST_INS_WALK || state_reg == dotq_pkg::ST_FIRE_HEAD))
        else $error("fire not followed by reinsert or head read");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == dotq_pkg::ST_DISPATCH)
        else $error("load did not enter dispatch");
    a_status_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.status |=> s_tready)
        else $error("status word not followed by idle");

endmodule

// File: rtl/dotq_datapath.sv
// slot store, sorted order list, time and output register of the timer queue
// depends on dotq_pkg; commanded by dotq_ctrl
module dotq_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  dotq_pkg::dp_cmd_t  cmd,
    output dotq_pkg::dp_stat_t st,
    input  logic [103:0]       s_tdata,
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [31:0]        cfg_wdata,
    output logic [103:0]       m_tdata,
    output logic               m_tuser,
    output logic               m_tlast,
    output logic               m_tvalid,
    input  logic               m_tready
);

    localparam int N = dotq_pkg::NUM_SLOTS;
    localparam int SW = dotq_pkg::SLOT_W;
    localparam int CW = dotq_pkg::CNT_W;
    localparam int FW = dotq_pkg::FIRE_W;

    logic [1:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [63:0] tv_reg;
    logic        rel_reg;
    logic [31:0] per_reg;
    logic [63:0] time_reg;
    logic [31:0] imin_reg;
    logic [31:0] imax_reg;
    logic [N-1:0] armed_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [SW-1:0] order_reg [N];
    logic [SW-1:0] order_next [N];
    logic [63:0] deadline_reg [N];
    logic [31:0] period_reg [N];
    logic [SW-1:0] cur_slot_reg;
    logic [63:0] cur_dl_reg;
    logic [CW-1:0] ins_pos_reg;
    logic [SW-1:0] ins_slot_reg;
    logic [63:0] ins_d_reg;
    logic [FW-1:0] fire_cnt_reg;
    logic [63:0] diff_reg;
    logic        past_reg;
    logic        m_tvalid_reg;
    logic        m_tuser_reg;
    logic        m_tlast_reg;
    logic [3:0]  out_slot_reg;
    logic [63:0] out_dl_reg;
    logic [31:0] out_delay_reg;

    logic [SW-1:0] slot_idx;
    logic [SW-1:0] rd_addr;
    logic [63:0]   rd_dl;
    logic [SW-1:0] rm_slot;
    logic [SW-1:0] rm_idx;
    logic          rm_hit;
    logic          do_rm;
    logic [63:0]   arm_dl;
    logic [31:0]   per_cur;
    logic          periodic;
    logic [63:0]   fire_dl;
    logic [31:0]   delay;
    logic          out_free;

    assign slot_idx = SW'(slot_reg);
    assign rd_addr  = cmd.ins_rd ? order_reg[ins_pos_reg[SW-1:0]] : order_reg[0];
    assign rd_dl    = deadline_reg[rd_addr];
    assign rm_slot  = cmd.fire ? cur_slot_reg : slot_idx;
    assign do_rm    = cmd.fire || ((cmd.arm || cmd.cancel) && armed_reg[slot_idx]);
    assign arm_dl   = rel_reg ? dotq_pkg::sat_add(time_reg, tv_reg) : tv_reg;
    assign per_cur  = period_reg[cur_slot_reg];
    assign periodic = per_cur != 32'd0;
    assign fire_dl  = dotq_pkg::sat_add(cur_dl_reg, {32'd0, per_cur});
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        rm_hit = 1'b0;
        rm_idx = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (CW'(i) < count_reg && order_reg[i] == rm_slot)
            begin
                rm_hit = 1'b1;
                rm_idx = SW'(i);
            end
        end
    end

    always_comb
    begin
        order_next = order_reg;
        count_next = count_reg;
        if (do_rm && rm_hit)
        begin
            for (int j = 0; j < N - 1; j++)
            begin
                if (SW'(j) >= rm_idx)
                begin
                    order_next[j] = order_reg[j + 1];
                end
            end
            count_next = count_reg - CW'(1);
        end
        else if (cmd.ins_put && count_reg < CW'(N))
        begin
            for (int j = 1; j < N; j++)
            begin
                if (CW'(j) > ins_pos_reg)
                begin
                    order_next[j] = order_reg[j - 1];
                end
            end
            for (int j = 0; j < N; j++)
            begin
                if (CW'(j) == ins_pos_reg)
                begin
                    order_next[j] = ins_slot_reg;
                end
            end
            count_next = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        if (count_reg == '0)
        begin
            delay = imax_reg;
        end
        else if (past_reg || diff_reg <= {32'd0, imin_reg})
        begin
            delay = imin_reg;
        end
        else if (diff_reg < {32'd0, imax_reg})
        begin
            delay = diff_reg[31:0];
        end
        else
        begin
            delay = imax_reg;
        end
    end

    always_comb
    begin
        st.op       = op_reg;
        st.slot_ok  = 32'(slot_reg) < 32'(N);
        st.ins_more = ins_pos_reg < count_reg && rd_dl <= ins_d_reg;
        st.due      = fire_cnt_reg < FW'(dotq_pkg::MAX_FIRES) && count_reg != '0
                      && cur_dl_reg <= time_reg;
        st.periodic = periodic;
        st.out_free = out_free;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imin_reg     <= dotq_pkg::RESET_INTERVAL_MIN;
            imax_reg     <= dotq_pkg::RESET_INTERVAL_MAX;
            time_reg     <= '0;
            armed_reg    <= '0;
            count_reg    <= '0;
            fire_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_addr == dotq_pkg::CFG_INTERVAL_MIN)
                begin
                    imin_reg <= cfg_wdata;
                end
                else
                begin
                    imax_reg <= cfg_wdata;
                end
            end
            count_reg <= count_next;
            if (cmd.tick)
            begin
                time_reg     <= tv_reg;
                fire_cnt_reg <= '0;
            end
            if (cmd.arm)
            begin
                armed_reg[slot_idx] <= 1'b1;
            end
            if (cmd.cancel)
            begin
                armed_reg[slot_idx] <= 1'b0;
            end
            if (cmd.fire)
            begin
                armed_reg[cur_slot_reg] <= periodic;
                fire_cnt_reg            <= fire_cnt_reg + FW'(1);
            end
            if (cmd.fire || cmd.status)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
        if (cmd.load)
        begin
            op_reg   <= s_tdata[1:0];
            slot_reg <= s_tdata[5:2];
            tv_reg   <= s_tdata[69:6];
            rel_reg  <= s_tdata[70];
            per_reg  <= s_tdata[102:71];
        end
        if (cmd.arm)
        begin
            deadline_reg[slot_idx] <= arm_dl;
            period_reg[slot_idx]   <= per_reg;
            ins_slot_reg           <= slot_idx;
            ins_d_reg              <= arm_dl;
            ins_pos_reg            <= '0;
        end
        if (cmd.cancel)
        begin
            deadline_reg[slot_idx] <= '0;
            period_reg[slot_idx]   <= '0;
        end
        if (cmd.fire)
        begin
            deadline_reg[cur_slot_reg] <= periodic ? fire_dl : 64'd0;
            ins_slot_reg               <= cur_slot_reg;
            ins_d_reg                  <= fire_dl;
            ins_pos_reg                <= '0;
            m_tuser_reg                <= dotq_pkg::KIND_FIRE;
            m_tlast_reg                <= 1'b0;
            out_slot_reg               <= 4'(cur_slot_reg);
            out_dl_reg                 <= cur_dl_reg;
            out_delay_reg              <= '0;
        end
        if (cmd.ins_step)
        begin
            ins_pos_reg <= ins_pos_reg + CW'(1);
        end
        if (cmd.head_read)
        begin
            cur_slot_reg <= order_reg[0];
            cur_dl_reg   <= rd_dl;
        end
        if (cmd.diff)
        begin
            diff_reg <= cur_dl_reg - time_reg;
            past_reg <= cur_dl_reg <= time_reg;
        end
        if (cmd.status)
        begin
            m_tuser_reg   <= dotq_pkg::KIND_STATUS;
            m_tlast_reg   <= 1'b1;
            out_slot_reg  <= '0;
            out_dl_reg    <= '0;
            out_delay_reg <= delay;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {4'd0, out_delay_reg, out_dl_reg, out_slot_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("armed count beyond slot count");
    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_cnt_reg <= FW'(dotq_pkg::MAX_FIRES))
        else $error("fire count beyond limit");
    a_list_matches_armed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> CW'($countones(armed_reg)) == count_reg)
        else $error("order list length differs from armed slots");
    a_fire_due: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fire |-> cur_dl_reg <= time_reg)
        else $error("slot fired before its deadline");

endmodule

// File: rtl/deadline_ordered_timer_queue.sv
// deadline ordered timer queue: arm, cancel and tick words in, fire and status words out
// an arm word is dispatched, armed and walked to its place in the sorted list, then status;
// cancel goes to status; tick fires due heads, walking periodic ones back in, then status
// the sorted order list is walked one entry a cycle through a single deadline read port
// one input word at a time; the next is taken once the status word is in the output register
// reset (rst_n, async, active low) empties the queue, clears time and loads default intervals
module deadline_ordered_timer_queue
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // mode, slot, time_value, relative, period, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // fired_slot, fired_deadline, next_delay, zero pad
    output logic         m_tuser,   // kind
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata
);

    dotq_pkg::dp_cmd_t  cmd;
    dotq_pkg::dp_stat_t st;

    dotq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    dotq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .s_tdata   (s_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready)
    );

endmodule

// File: verif/deadline_ordered_timer_queue_tb.sv
// testbench for deadline_ordered_timer_queue: arm, cancel and tick words with a timer predictor
// depends on dotq_pkg and the block under test; checks fire and status words field by field
`timescale 1ns / 1ps

module deadline_ordered_timer_queue_tb;

    typedef struct packed {
        logic        kind;
        logic [3:0]  fslot;
        logic [63:0] fdl;
        logic [31:0] delay;
        logic        lst;
    } timer_word_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en;
    logic         cfg_addr;
    logic [31:0]  cfg_wdata;

    // timer predictor state
    logic [63:0] dl_q [dotq_pkg::NUM_SLOTS];
    logic [31:0] per_q [dotq_pkg::NUM_SLOTS];
    logic        armed_q [dotq_pkg::NUM_SLOTS];
    logic [3:0]  order_q [dotq_pkg::NUM_SLOTS];
    int          n_armed;
    logic [63:0] now_q;
    logic [31:0] ivl_min;
    logic [31:0] ivl_max;

    timer_word_t expected_words [$];
    int          errors;
    int          stall_pct;

    deadline_ordered_timer_queue u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic void unlink_slot(logic [3:0] s);
        for (int i = 0; i < n_armed; i++)
        begin
            if (order_q[i] == s)
            begin
                for (int j = i; j + 1 < n_armed; j++)
                    order_q[j] = order_q[j + 1];
                n_armed--;
                return;
            end
        end
    endfunction

    function automatic void link_slot(logic [3:0] s);
        int pos;
        pos = 0;
        if (n_armed >= dotq_pkg::NUM_SLOTS)
            return;
        while (pos < n_armed && dl_q[order_q[pos]] <= dl_q[s])
            pos++;
        for (int j = n_armed; j > pos; j--)
            order_q[j] = order_q[j - 1];
        order_q[pos] = s;
        n_armed++;
    endfunction

    function automatic logic [31:0] wake_delay_now();
        logic [63:0] d;
        if (n_armed == 0)
            return ivl_max;
        d = dl_q[order_q[0]];
        if (d <= now_q || d - now_q <= {32'd0, ivl_min})
            return ivl_min;
        if (d - now_q < {32'd0, ivl_max})
            return 32'(d - now_q);
        return ivl_max;
    endfunction

    function automatic void predict_timer(logic [1:0] mode, logic [3:0] s, logic [63:0] tv,
                                          logic rel, logic [31:0] per);
        timer_word_t w;
        int fires;
        logic [3:0] h;
        logic [63:0] d;
        if (mode == dotq_pkg::OP_ARM)
        begin
            if (armed_q[s])
                unlink_slot(s);
            dl_q[s] = rel ? add_clamped(now_q, tv) : tv;
            per_q[s] = per;
            armed_q[s] = 1'b1;
            link_slot(s);
        end
        else if (mode == dotq_pkg::OP_CANCEL)
        begin
            if (armed_q[s])
                unlink_slot(s);
            armed_q[s] = 1'b0;
            dl_q[s] = '0;
            per_q[s] = '0;
        end
        else if (mode == dotq_pkg::OP_TICK)
        begin
            fires = 0;
            now_q = tv;
            while (fires < dotq_pkg::MAX_FIRES && n_armed > 0)
            begin
                h = order_q[0];
                d = dl_q[h];
                if (d > now_q)
                    break;
                unlink_slot(h);
                w = '{dotq_pkg::KIND_FIRE, h, d, 32'd0, 1'b0};
                expected_words.push_back(w);
                fires++;
                if (per_q[h] != 0)
                begin
                    dl_q[h] = add_clamped(d, {32'd0, per_q[h]});
                    link_slot(h);
                end
                else
                begin
                    armed_q[h] = 1'b0;
                    dl_q[h] = '0;
                end
            end
        end
        w = '{dotq_pkg::KIND_STATUS, 4'd0, 64'd0, wake_delay_now(), 1'b1};
        expected_words.push_back(w);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // send one word with a caller-given gap in front; burst length handled by caller
    task automatic send_word(logic [1:0] mode, logic [3:0] s, logic [63:0] tv, logic rel,
                             logic [31:0] per, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, per, rel, tv, s, mode};
        predict_timer(mode, s, tv, rel, per);
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_interval(logic idx, logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == dotq_pkg::CFG_INTERVAL_MIN)
            ivl_min = v;
        else
            ivl_max = v;
        @(posedge clk);
    endtask

    // receiver stall pattern and word checker
    always @(posedge clk)
    begin
        timer_word_t w;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
                end
                else
                begin
                    w = expected_words.pop_front();
                    if (m_tuser != w.kind)
                        report_mismatch("kind", 64'(m_tuser), 64'(w.kind));
                    if (m_tdata[3:0] != w.fslot)
                        report_mismatch("fired_slot", 64'(m_tdata[3:0]), 64'(w.fslot));
                    if (m_tdata[67:4] != w.fdl)
                        report_mismatch("fired_deadline", m_tdata[67:4], w.fdl);
                    if (m_tdata[99:68] != w.delay)
                        report_mismatch("next_delay", 64'(m_tdata[99:68]), 64'(w.delay));
                    if (m_tlast != w.lst)
                        report_mismatch("last", 64'(m_tlast), 64'(w.lst));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic test_directed();
        send_word(dotq_pkg::OP_TICK, 4'd0, 64'd0, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_ARM, 4'd0, 64'd1000, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_ARM, 4'd15, 64'd1000, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_ARM, 4'd3, 64'd200, 1'b1, 32'd300, 0);
        send_word(dotq_pkg::OP_ARM, 4'd0, 64'd100, 1'b0, 32'd0, 1);
        send_word(dotq_pkg::OP_ARM, 4'd7, 64'd10, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_CANCEL, 4'd7, 64'd0, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_CANCEL, 4'd9, 64'd0, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_RSVD, 4'd5, '1, 1'b1, '1, 0);
        send_word(dotq_pkg::OP_TICK, 4'd0, 64'd5000, 1'b0, 32'd0, 2);
        send_word(dotq_pkg::OP_ARM, 4'd1, 64'd1, 1'b0, 32'd1, 0);
        send_word(dotq_pkg::OP_TICK, 4'd0, 64'd6000, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_TICK, 4'd0, 64'd10, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_ARM, 4'd2, '1, 1'b1, '1, 0);
        send_word(dotq_pkg::OP_ARM, 4'd4, '1, 1'b0, '1, 0);
        send_word(dotq_pkg::OP_ARM, 4'd5, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, '1, 0);
        send_word(dotq_pkg::OP_TICK, 4'd0, '1, 1'b0, 32'd0, 0);
        send_word(dotq_pkg::OP_TICK, 4'd0, 64'd0, 1'b0, 32'd0, 0);
        for (int s = 0; s < dotq_pkg::NUM_SLOTS; s++)
            send_word(dotq_pkg::OP_CANCEL, 4'(s), 64'd0, 1'b0, 32'd0, 0);
        wait_drained();
    endtask

    task automatic test_random(int count, logic [63:0] span);
        int burst;
        int r;
        logic [1:0] mode;
        logic [63:0] tv;
        logic [63:0] tick_at;
        burst = 0;
        tick_at = now_q;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            mode = (r < 50) ? dotq_pkg::OP_ARM : (r < 65) ? dotq_pkg::OP_CANCEL :
                   (r < 97) ? dotq_pkg::OP_TICK : dotq_pkg::OP_RSVD;
            tv = {$urandom, $urandom};
            if ($urandom_range(9) != 0)
                tv = tv % span;
            if (mode == dotq_pkg::OP_TICK && $urandom_range(9) != 0)
            begin
                tick_at = tick_at + ($urandom % span);
                tv = tick_at;
            end
            if (burst == 0)
                burst = $urandom_range(8, 1);
            burst--;
            send_word(mode, 4'($urandom), tv, 1'($urandom),
                      ($urandom_range(2) == 0) ? $urandom : $urandom % 32'(span),
                      (burst == 0) ? $urandom_range(30) : 0);
            if (i == count / 2)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_intervals();
        write_interval(dotq_pkg::CFG_INTERVAL_MIN, 32'd0);
        write_interval(dotq_pkg::CFG_INTERVAL_MAX, '1);
        test_random(120, 64'd5000);
        write_interval(dotq_pkg::CFG_INTERVAL_MIN, '1);
        write_interval(dotq_pkg::CFG_INTERVAL_MAX, 32'd1);
        test_random(60, 64'd100000);
        write_interval(dotq_pkg::CFG_INTERVAL_MIN, 32'd200);
        write_interval(dotq_pkg::CFG_INTERVAL_MAX, 32'd3000);
        test_random(120, 64'd2000);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = dotq_pkg::CFG_INTERVAL_MIN;
        cfg_wdata = '0;
        errors = 0;
        stall_pct = 30;
        for (int s = 0; s < dotq_pkg::NUM_SLOTS; s++)
        begin
            dl_q[s] = '0;
            per_q[s] = '0;
            armed_q[s] = 1'b0;
            order_q[s] = '0;
        end
        n_armed = 0;
        now_q = '0;
        ivl_min = dotq_pkg::RESET_INTERVAL_MIN;
        ivl_max = dotq_pkg::RESET_INTERVAL_MAX;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_pct = 0;
        test_random(170, 64'd200000000);
        stall_pct = 60;
        test_intervals();
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dotq_pkg.sv
rtl/dotq_ctrl.sv
rtl/dotq_datapath.sv
rtl/deadline_ordered_timer_queue.sv
verif/deadline_ordered_timer_queue_tb.sv
